/* rtl/core/bdlmp_pkg.sv */
// shared types and constants for the button debouncer
package bdlmp_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [1:0] REG_LONG_PERIOD    = 2'd1;
    localparam logic [1:0] REG_MULTI_GAP      = 2'd2;
    localparam logic [1:0] REG_PRESSED_LEVEL  = 2'd3;

    // reset values of the configuration registers
    localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd20;
    localparam logic [15:0] LONG_PERIOD_RST    = 16'd0;
    localparam logic [15:0] MULTI_GAP_RST      = 16'd600;
    localparam logic        PRESSED_LEVEL_RST  = 1'b0;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // saturation limits
    localparam logic [8:0]  STEADY_MAX = 9'd511;
    localparam logic [15:0] REPEAT_MAX = 16'hFFFF;
    localparam logic [7:0]  RUN_MAX    = 8'hFF;

    // configuration register set
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_period;
        logic [15:0] multi_press_gap;
        logic        pressed_level;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic        pressed;
        logic        changed;
        logic        press_event;
        logic        long_press_event;
        logic [15:0] long_press_repeat;
        logic        multi_press_event;
        logic [7:0]  multi_press_count;
    } result_t;

endpackage

/* rtl/core/bdlmp_cfg.sv */
// configuration register file with index decode
module bdlmp_cfg
    import bdlmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_TICKS_RST;
            cfg_reg.long_press_period <= LONG_PERIOD_RST;
            cfg_reg.multi_press_gap   <= MULTI_GAP_RST;
            cfg_reg.pressed_level     <= PRESSED_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks    <= cfg_data[7:0];
                REG_LONG_PERIOD:    cfg_reg.long_press_period <= cfg_data;
                REG_MULTI_GAP:      cfg_reg.multi_press_gap   <= cfg_data;
                REG_PRESSED_LEVEL:  cfg_reg.pressed_level     <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/bdlmp_core.sv */
// debounce, long-press and multi-press state with per-tick result logic
module bdlmp_core
    import bdlmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    tick,
    input  logic    raw_level,
    output result_t result
);

    logic        prev_raw_reg,    prev_raw_next;
    logic        deb_reg,         deb_next;
    logic [8:0]  steady_reg,      steady_next;
    logic        long_act_reg,    long_act_next;
    logic [15:0] long_cnt_reg,    long_cnt_next;
    logic [15:0] repeat_reg,      repeat_next;
    logic [15:0] gap_reg,         gap_next;
    logic [7:0]  run_reg,         run_next;

    logic        sample;
    logic [15:0] gap_dec;

    // next state and result for one tick
    always_comb
    begin
        sample  = (raw_level == cfg.pressed_level);
        gap_dec = (gap_reg != 16'd0) ? gap_reg - 16'd1 : gap_reg;

        prev_raw_next = sample;
        deb_next      = deb_reg;
        long_act_next = long_act_reg;
        long_cnt_next = long_cnt_reg;
        repeat_next   = repeat_reg;
        gap_next      = gap_dec;
        run_next      = run_reg;
        result        = '0;

        // steady counter, saturating
        if (sample != prev_raw_reg)
            steady_next = 9'd0;
        else if (steady_reg < STEADY_MAX)
            steady_next = steady_reg + 9'd1;
        else
            steady_next = steady_reg;

        if (steady_next > {1'b0, cfg.debounce_ticks} && sample != deb_reg)
        begin
            // accepted change of debounced state
            deb_next       = sample;
            result.changed = 1'b1;
            repeat_next    = 16'd0;
            if (sample && cfg.long_press_period != 16'd0)
            begin
                long_act_next = 1'b1;
                long_cnt_next = cfg.long_press_period;
            end
            else
            begin
                long_act_next = 1'b0;
                long_cnt_next = 16'd0;
            end
            if (sample)
            begin
                result.press_event = 1'b1;
                if (gap_dec != 16'd0)
                begin
                    if (run_reg < RUN_MAX)
                        run_next = run_reg + 8'd1;
                    result.multi_press_event = 1'b1;
                end
                else
                begin
                    run_next = 8'd1;
                end
                gap_next = cfg.multi_press_gap;
            end
        end
        else if (long_act_reg)
        begin
            // long-press timer
            if (long_cnt_reg <= 16'd1)
            begin
                if (repeat_reg < REPEAT_MAX)
                    repeat_next = repeat_reg + 16'd1;
                result.long_press_event  = 1'b1;
                result.long_press_repeat = repeat_next;
                long_cnt_next            = cfg.long_press_period;
            end
            else
            begin
                long_cnt_next = long_cnt_reg - 16'd1;
            end
        end

        result.pressed           = deb_next;
        result.multi_press_count = run_next;
    end

    // state update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b0;
            deb_reg      <= 1'b0;
            steady_reg   <= 9'd0;
            long_act_reg <= 1'b0;
            long_cnt_reg <= 16'd0;
            repeat_reg   <= 16'd0;
            gap_reg      <= 16'd0;
            run_reg      <= 8'd0;
        end
        else if (tick)
        begin
            prev_raw_reg <= prev_raw_next;
            deb_reg      <= deb_next;
            steady_reg   <= steady_next;
            long_act_reg <= long_act_next;
            long_cnt_reg <= long_cnt_next;
            repeat_reg   <= repeat_next;
            gap_reg      <= gap_next;
            run_reg      <= run_next;
        end
    end

endmodule

/* rtl/core/bdlmp_outq.sv */
// result register with skid stage
module bdlmp_outq
    import bdlmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

/* rtl/core/button_debounce_long_multi_press.sv */
// top level of the button debouncer with long-press and multi-press events
//
// Each request on the input channel is one millisecond tick carrying the
// raw pin level. Every request produces exactly one result request on the
// output channel: debounced level, change and press flags, long-press
// event with repeat number, and multi-press event with run count.
// Each result is registered in the output stage. Throughput is one tick
// per cycle while in_ready is high; the state update is a single pass of
// counter logic, and the output register plus a skid stage keep in_ready
// high while one result waits. in_ready drops only when both stages are
// full. A stalled receiver holds its result stable; ticks are never
// dropped. Reset (rst_n, asynchronous) treats the button as released,
// clears all counters and loads the register defaults: debounce 20,
// long-press period 0 (off), multi-press gap 600, pressed level 0.
// Configuration is written via cfg_we/cfg_index/cfg_data; the user must
// write it only while no tick is in flight; the block does not enforce it.
module button_debounce_long_multi_press
    import bdlmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  raw_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pressed,
    output logic                  changed,
    output logic                  press_event,
    output logic                  long_press_event,
    output logic [15:0]           long_press_repeat,
    output logic                  multi_press_event,
    output logic [7:0]            multi_press_count
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    tick;

    assign tick = in_valid && in_ready;

    // configuration registers
    bdlmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // per-tick state update
    bdlmp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tick      (tick),
        .raw_level (raw_level),
        .result    (step_result)
    );

    // output stage
    bdlmp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tick),
        .push_data  (step_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign pressed           = out_data.pressed;
    assign changed           = out_data.changed;
    assign press_event       = out_data.press_event;
    assign long_press_event  = out_data.long_press_event;
    assign long_press_repeat = out_data.long_press_repeat;
    assign multi_press_event = out_data.multi_press_event;
    assign multi_press_count = out_data.multi_press_count;

endmodule

/* tb/tb_button_debounce_long_multi_press.sv */
// self-checking testbench for the button debouncer with long-press and multi-press events
`timescale 1ns / 100ps

module tb_button_debounce_long_multi_press;

    import bdlmp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 5;

    typedef enum logic {ROW_TICK, ROW_CONFIG} row_kind_t;

    // one row of the directed table: a tick or a full register set
    typedef struct packed {
        row_kind_t kind;
        logic      raw;
        logic      has_typed;
        result_t   typed;
        cfg_t      cfg;
    } dir_row_t;

    localparam result_t ZERO_RES    = '0;
    localparam result_t FIRST_PRESS = '{1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 8'd1};
    localparam cfg_t    CFG_FAST    = '{8'd0, 16'd2, 16'hFFFF, 1'b0};
    localparam cfg_t    CFG_LP_OFF  = '{8'd0, 16'd0, 16'hFFFF, 1'b0};
    localparam cfg_t    CFG_FLIP    = '{8'd0, 16'd3, 16'd0, 1'b1};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  raw_level;
    logic                  out_valid;
    logic                  out_ready;
    logic                  pressed;
    logic                  changed;
    logic                  press_event;
    logic                  long_press_event;
    logic [15:0]           long_press_repeat;
    logic                  multi_press_event;
    logic [7:0]            multi_press_count;

    // typed expectation travelling with the request
    logic    row_has_typed;
    result_t row_typed;

    // predictor copy of registers and state
    cfg_t        cur_cfg;
    logic        prev_sample;
    logic        db_pressed;
    logic [8:0]  steady_cnt;
    logic        lp_active;
    logic [15:0] lp_countdown;
    logic [15:0] lp_repeat;
    logic [15:0] gap_left;
    logic [7:0]  run_cnt;

    result_t tick_results_due[$];
    int      mismatch_count;
    bit      send_burst;

    // directed table: after reset, long-press repeats, period zero while held,
    // period change while held, polarity flip, gap of zero
    dir_row_t directed_rows [28] = '{
        '{ROW_TICK,   1'b1, 1'b1, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b1, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b1, ZERO_RES,    '0},
        '{ROW_CONFIG, 1'b0, 1'b0, ZERO_RES,    CFG_FAST},
        '{ROW_TICK,   1'b0, 1'b1, FIRST_PRESS, '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_CONFIG, 1'b0, 1'b0, ZERO_RES,    CFG_LP_OFF},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_CONFIG, 1'b0, 1'b0, ZERO_RES,    CFG_FLIP},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b0, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0},
        '{ROW_TICK,   1'b1, 1'b0, ZERO_RES,    '0}
    };

    button_debounce_long_multi_press dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_level         (raw_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pressed           (pressed),
        .changed           (changed),
        .press_event       (press_event),
        .long_press_event  (long_press_event),
        .long_press_repeat (long_press_repeat),
        .multi_press_event (multi_press_event),
        .multi_press_count (multi_press_count)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one debounce tick: advance the predicted state and form the result
    function automatic result_t debounce_tick(input logic raw);
        result_t r;
        logic    sample;
        r = '0;
        sample = (raw == cur_cfg.pressed_level);
        if (gap_left != 16'd0)
            gap_left = gap_left - 16'd1;
        if (sample != prev_sample)
            steady_cnt = '0;
        else if (steady_cnt != STEADY_MAX)
            steady_cnt = steady_cnt + 9'd1;
        prev_sample = sample;

        if (steady_cnt > {1'b0, cur_cfg.debounce_ticks} && sample != db_pressed)
        begin
            db_pressed = sample;
            r.changed  = 1'b1;
            lp_repeat  = '0;
            if (sample && cur_cfg.long_press_period != 16'd0)
            begin
                lp_active    = 1'b1;
                lp_countdown = cur_cfg.long_press_period;
            end
            else
            begin
                lp_active    = 1'b0;
                lp_countdown = '0;
            end
            // a press inside the gap window extends the run
            if (sample)
            begin
                r.press_event = 1'b1;
                if (gap_left != 16'd0)
                begin
                    if (run_cnt != RUN_MAX)
                        run_cnt = run_cnt + 8'd1;
                    r.multi_press_event = 1'b1;
                end
                else
                    run_cnt = 8'd1;
                gap_left = cur_cfg.multi_press_gap;
            end
        end
        else if (lp_active)
        begin
            // held: count down to the next long-press event
            if (lp_countdown <= 16'd1)
            begin
                if (lp_repeat != REPEAT_MAX)
                    lp_repeat = lp_repeat + 16'd1;
                r.long_press_event  = 1'b1;
                r.long_press_repeat = lp_repeat;
                lp_countdown        = cur_cfg.long_press_period;
            end
            else
                lp_countdown = lp_countdown - 16'd1;
        end

        r.pressed           = db_pressed;
        r.multi_press_count = run_cnt;
        return r;
    endfunction

    // field-by-field comparison of one result
    task automatic compare_result(input result_t want, input result_t got);
        if (got.pressed !== want.pressed)
        begin
            $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
            mismatch_count++;
        end
        if (got.changed !== want.changed)
        begin
            $error("changed: expected %0d, got %0d", want.changed, got.changed);
            mismatch_count++;
        end
        if (got.press_event !== want.press_event)
        begin
            $error("press_event: expected %0d, got %0d", want.press_event, got.press_event);
            mismatch_count++;
        end
        if (got.long_press_event !== want.long_press_event)
        begin
            $error("long_press_event: expected %0d, got %0d",
                   want.long_press_event, got.long_press_event);
            mismatch_count++;
        end
        if (got.long_press_repeat !== want.long_press_repeat)
        begin
            $error("long_press_repeat: expected %0d, got %0d",
                   want.long_press_repeat, got.long_press_repeat);
            mismatch_count++;
        end
        if (got.multi_press_event !== want.multi_press_event)
        begin
            $error("multi_press_event: expected %0d, got %0d",
                   want.multi_press_event, got.multi_press_event);
            mismatch_count++;
        end
        if (got.multi_press_count !== want.multi_press_count)
        begin
            $error("multi_press_count: expected %0d, got %0d",
                   want.multi_press_count, got.multi_press_count);
            mismatch_count++;
        end
    endtask

    // monitor: results are checked before the same edge's request is predicted
    always @(posedge clk)
    begin
        result_t seen;
        result_t due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.pressed           = pressed;
                seen.changed           = changed;
                seen.press_event       = press_event;
                seen.long_press_event  = long_press_event;
                seen.long_press_repeat = long_press_repeat;
                seen.multi_press_event = multi_press_event;
                seen.multi_press_count = multi_press_count;
                if (tick_results_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end
                else
                    compare_result(tick_results_due.pop_front(), seen);
            end
            if (in_valid && in_ready)
            begin
                due = debounce_tick(raw_level);
                if (row_has_typed)
                    tick_results_due.push_back(row_typed);
                else
                    tick_results_due.push_back(due);
            end
        end
    end

    // offer one tick request after a random gap and wait for acceptance
    task automatic send_tick(input logic raw, input logic has_typed, input result_t typed);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        raw_level     <= raw;
        row_has_typed <= has_typed;
        row_typed     <= typed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // write all four registers once the block has drained
    task automatic apply_config(input cfg_t cfg);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tick_results_due.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE_TICKS;
        cfg_data  <= CFG_DATA_W'(cfg.debounce_ticks);
        @(posedge clk);
        cfg_index <= REG_LONG_PERIOD;
        cfg_data  <= cfg.long_press_period;
        @(posedge clk);
        cfg_index <= REG_MULTI_GAP;
        cfg_data  <= cfg.multi_press_gap;
        @(posedge clk);
        cfg_index <= REG_PRESSED_LEVEL;
        cfg_data  <= CFG_DATA_W'(cfg.pressed_level);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = cfg;
    endtask

    // alternating pin runs with occasional single-tick bounces
    task automatic send_press_train(input int n_ticks, input int run_min, input int run_max,
                                    input int noise_pct);
        logic level;
        int   run_left;
        level    = 1'b0;
        run_left = 0;
        repeat (n_ticks)
        begin
            if (run_left == 0)
            begin
                level    = ~level;
                run_left = $urandom_range(run_min, run_max);
            end
            run_left--;
            if ($urandom_range(0, 99) < noise_pct)
                send_tick(~level, 1'b0, ZERO_RES);
            else
                send_tick(level, 1'b0, ZERO_RES);
        end
    endtask

    // receiver: random stalls, bursts, and one long hold-off
    initial
    begin
        int stall;
        int results_taken;
        bit recv_burst;
        results_taken = 0;
        recv_burst    = 1'b0;
        out_ready     = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == HOLD_OFF_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 29) == 0)
                recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_taken++;
        end
    end

    // watchdog on cycles with no request accepted on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        cfg_t mixed_cfg;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        raw_level     = 1'b0;
        row_has_typed = 1'b0;
        row_typed     = '0;
        send_burst    = 1'b0;
        mismatch_count = 0;
        cur_cfg       = '{DEBOUNCE_TICKS_RST, LONG_PERIOD_RST, MULTI_GAP_RST, PRESSED_LEVEL_RST};
        prev_sample   = 1'b0;
        db_pressed    = 1'b0;
        steady_cnt    = '0;
        lp_active     = 1'b0;
        lp_countdown  = '0;
        lp_repeat     = '0;
        gap_left      = '0;
        run_cnt       = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                apply_config(directed_rows[i].cfg);
            else
                send_tick(directed_rows[i].raw, directed_rows[i].has_typed,
                          directed_rows[i].typed);
        end

        // fastest debounce, longest gap: drive the run count into saturation
        apply_config('{8'd0, 16'd1, 16'hFFFF, 1'b0});
        send_press_train(1032, 2, 2, 0);

        // slowest debounce and longest period: one press held past the window
        apply_config('{8'd255, 16'hFFFF, 16'd1, 1'b1});
        send_press_train(265, 260, 265, 0);

        // short random settings with bouncy presses
        repeat (3)
        begin
            mixed_cfg.debounce_ticks    = 8'($urandom_range(0, 4));
            mixed_cfg.long_press_period = 16'($urandom_range(0, 5));
            mixed_cfg.multi_press_gap   = 16'($urandom_range(0, 30));
            mixed_cfg.pressed_level     = 1'($urandom_range(0, 1));
            apply_config(mixed_cfg);
            send_press_train(40, 1, 10, 10);
        end

        in_valid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* button_debounce_long_multi_press.f */
rtl/core/bdlmp_pkg.sv
rtl/core/bdlmp_cfg.sv
rtl/core/bdlmp_core.sv
rtl/core/bdlmp_outq.sv
rtl/core/button_debounce_long_multi_press.sv
tb/tb_button_debounce_long_multi_press.sv
